// ----- rtl/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// bss_pkg
// Shared widths, reset values and codes of the burst spray sequencer.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int TIMER_W = 16;
  localparam int TIME_W  = 16;
  localparam int COUNT_W = 4;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0]  RUN1_RST    = TIME_W'(50);
  localparam logic [TIME_W-1:0]  GAP1_RST    = TIME_W'(0);
  localparam logic [TIME_W-1:0]  PERIOD1_RST = TIME_W'(3000);
  localparam logic [TIME_W-1:0]  RUN2_RST    = TIME_W'(30);
  localparam logic [TIME_W-1:0]  GAP2_RST    = TIME_W'(5);
  localparam logic [TIME_W-1:0]  PERIOD2_RST = TIME_W'(1800);
  localparam logic [COUNT_W-1:0] BURSTS_RST  = COUNT_W'(2);

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_ONE  = 2'd1,
    MODE_TWO  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN1    = 3'd0,
    CFG_GAP1    = 3'd1,
    CFG_PERIOD1 = 3'd2,
    CFG_RUN2    = 3'd3,
    CFG_GAP2    = 3'd4,
    CFG_PERIOD2 = 3'd5,
    CFG_BURSTS  = 3'd6,
    CFG_NONE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                 motor_running;
    logic                 oneshot_active;
    logic                 oneshot_gap_wait;
    logic [COUNT_W-1:0]   oneshot_bursts;
    logic                 periodic_gap_wait;
    logic [COUNT_W-1:0]   periodic_bursts;
    logic                 period_elapsed;
    logic [TIMER_W-1:0]   periodic_timer;
    logic [TIMER_W-1:0]   oneshot_timer;
    logic [TIME_W-1:0]    oneshot_run_limit;
  } seq_state_t;

endpackage

// ----- rtl/burst_spray_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// burst_spray_sequencer_unit
// Spray motor sequencer: one control step per input beat, one result beat.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | tick power_on start_request
//         |           |                    | single_request mode
// out     | output    | out_valid/out_stall| motor_enable oneshot_busy in_gap
// cfg     | input     | cfg_valid/cfg_ready| cfg_index cfg_data
//
// A beat is accepted into an input register and is processed from there;
// its result beat is registered when the result register can move.
// One beat is accepted every cycle while in_stall is low; the step logic
// between the input and result registers updates the sequencer state at once.
// Reset clears the sequencer state and restores the register defaults.
// While a result is stalled, one further beat is held in the input register.
// ----------------------------------------------------------------------------
module burst_spray_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          tick,
  input  logic                          power_on,
  input  logic                          start_request,
  input  logic                          single_request,
  input  logic [bss_pkg::MODE_W-1:0]    mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          motor_enable,
  output logic                          oneshot_busy,
  output logic                          in_gap,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bss_pkg::*;

  logic [TIME_W-1:0]  run_time_mode1, gap_time_mode1, period_time_mode1;
  logic [TIME_W-1:0]  run_time_mode2, gap_time_mode2, period_time_mode2;
  logic [COUNT_W-1:0] bursts_per_cycle;

  logic              s1_valid;
  logic              s1_tick, s1_power, s1_start, s1_single;
  logic [MODE_W-1:0] s1_mode;

  seq_state_t st, st_next;
  logic       advance;
  logic       in_accept;
  logic       gap_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_time_mode1    <= RUN1_RST;
      gap_time_mode1    <= GAP1_RST;
      period_time_mode1 <= PERIOD1_RST;
      run_time_mode2    <= RUN2_RST;
      gap_time_mode2    <= GAP2_RST;
      period_time_mode2 <= PERIOD2_RST;
      bursts_per_cycle  <= BURSTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RUN1:    run_time_mode1    <= cfg_data;
        CFG_GAP1:    gap_time_mode1    <= cfg_data;
        CFG_PERIOD1: period_time_mode1 <= cfg_data;
        CFG_RUN2:    run_time_mode2    <= cfg_data;
        CFG_GAP2:    gap_time_mode2    <= cfg_data;
        CFG_PERIOD2: period_time_mode2 <= cfg_data;
        CFG_BURSTS:  bursts_per_cycle  <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tick   <= tick;
      s1_power  <= power_on;
      s1_start  <= start_request;
      s1_single <= single_request;
      s1_mode   <= mode;
    end
  end

  always_comb begin
    logic [TIME_W-1:0] run, gap, per;
    logic              seq_mode;
    st_next  = st;
    seq_mode = (mode_t'(s1_mode) == MODE_ONE) || (mode_t'(s1_mode) == MODE_TWO);
    run = (mode_t'(s1_mode) == MODE_ONE) ? run_time_mode1 : run_time_mode2;
    gap = (mode_t'(s1_mode) == MODE_ONE) ? gap_time_mode1 : gap_time_mode2;
    per = (mode_t'(s1_mode) == MODE_ONE) ? period_time_mode1 : period_time_mode2;

    if (s1_tick) begin
      if (st_next.periodic_timer != TIMER_MAX) begin
        st_next.periodic_timer = st_next.periodic_timer + TIMER_W'(1);
      end
      if (st_next.oneshot_timer != TIMER_MAX) begin
        st_next.oneshot_timer = st_next.oneshot_timer + TIMER_W'(1);
      end
    end

    if (!s1_power) begin
      st_next = '0;
    end else begin
      if (s1_single) begin
        st_next.oneshot_active = 1'b1;
        st_next.oneshot_timer  = '0;
      end
      if (seq_mode) begin
        if (s1_start) begin
          st_next.motor_running  = 1'b1;
          st_next.periodic_timer = '0;
        end
        if (st_next.oneshot_active) begin
          if (!st_next.motor_running && !st_next.oneshot_gap_wait) begin
            st_next.motor_running = 1'b1;
          end
          if (st_next.oneshot_timer >= st_next.oneshot_run_limit) begin
            st_next.oneshot_timer = '0;
            if (gap != '0) begin
              st_next.oneshot_gap_wait = 1'b1;
              st_next.oneshot_bursts   = st_next.oneshot_bursts + COUNT_W'(1);
              if (st_next.oneshot_bursts >= bursts_per_cycle) begin
                st_next.oneshot_bursts   = '0;
                st_next.oneshot_gap_wait = 1'b0;
                st_next.oneshot_active   = 1'b0;
              end
            end else begin
              st_next.oneshot_gap_wait = 1'b0;
              st_next.oneshot_active   = 1'b0;
            end
            if (st_next.period_elapsed) begin
              st_next.periodic_timer = '0;
              st_next.period_elapsed = 1'b0;
            end
            st_next.motor_running = 1'b0;
          end else if (st_next.oneshot_gap_wait && (st_next.oneshot_timer >= gap)) begin
            st_next.oneshot_timer    = '0;
            st_next.oneshot_gap_wait = 1'b0;
            st_next.motor_running    = 1'b1;
          end
        end else begin
          if (st_next.motor_running) begin
            st_next.oneshot_run_limit = run;
            if (st_next.periodic_timer >= run) begin
              st_next.periodic_timer = '0;
              if (gap != '0) begin
                st_next.periodic_bursts = st_next.periodic_bursts + COUNT_W'(1);
                if (st_next.periodic_bursts >= bursts_per_cycle) begin
                  st_next.periodic_bursts   = '0;
                  st_next.periodic_gap_wait = 1'b0;
                end else begin
                  st_next.periodic_gap_wait = 1'b1;
                end
              end else begin
                st_next.periodic_gap_wait = 1'b0;
              end
              st_next.motor_running = 1'b0;
            end
          end else if (st_next.periodic_gap_wait) begin
            if (st_next.periodic_timer >= gap) begin
              st_next.periodic_timer    = '0;
              st_next.periodic_gap_wait = 1'b0;
              st_next.period_elapsed    = 1'b1;
              st_next.motor_running     = 1'b1;
            end
          end else if (st_next.periodic_timer >= per) begin
            st_next.periodic_timer = '0;
            st_next.period_elapsed = 1'b1;
            st_next.motor_running  = 1'b1;
          end
        end
      end
    end
    gap_next = st_next.oneshot_active ? st_next.oneshot_gap_wait
                                      : st_next.periodic_gap_wait;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      motor_enable <= st_next.motor_running;
      oneshot_busy <= st_next.oneshot_active;
      in_gap       <= gap_next;
    end
  end

endmodule

// ----- rtl/bss_checker.sv -----
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks of the burst spray sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bss_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic motor_enable,
  input logic oneshot_busy,
  input logic in_gap,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result register can move");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_enable)
      && $stable(oneshot_busy) && $stable(in_gap))
    else $error("stalled result beat changed");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind burst_spray_sequencer_unit bss_checker u_bss_checker (.*);
